FILE: design/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared constants, codes, types and helpers for the PFM H-bridge driver.
// ----------------------------------------------------------------------------
package pfm_pkg;

    // Wait counter width
    localparam int COUNT_WIDTH = 24;

    // Field widths
    localparam int CFG_W   = 16;
    localparam int DUTY_W  = 8;
    localparam int MAG_W   = 7;
    localparam int KIND_W  = 2;
    localparam int OUT_W   = 16;

    // Full scale duty in percent
    localparam int DUTY_FULL = 100;
    localparam logic signed [DUTY_W-1:0] DUTY_POS = DUTY_W'(DUTY_FULL);
    localparam logic signed [DUTY_W-1:0] DUTY_NEG = -DUTY_POS;

    // Divider: on_time*100 fits 23 bits, padded to a multiple of the radix
    localparam int NUM_W      = 24;
    localparam int DIV_RADIX  = 3;
    localparam int DIV_CYCLES = NUM_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Wide width used ahead of counter saturation
    localparam int WIDE_W = 33;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRAKE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ON_TIME   = 1'b0;
    localparam logic CFG_DEAD_TIME = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_COMMIT
    } ctrl_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_item;
        logic mul;
        logic div_start;
        logic commit;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

    // Saturate a value into the wait counter range
    function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] max_w;
        max_w = WIDE_W'({COUNT_WIDTH{1'b1}});
        if (v > max_w)
        begin
            return {COUNT_WIDTH{1'b1}};
        end
        return v[COUNT_WIDTH-1:0];
    endfunction

endpackage

FILE: design/pfm_div.sv
// ----------------------------------------------------------------------------
// pfm_div
// Iterative restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module pfm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pfm_pkg::NUM_W-1:0]        num,
    input  logic [pfm_pkg::MAG_W-1:0]        den,
    output logic                             done,
    output logic [pfm_pkg::NUM_W-1:0]        quo
);

    logic [pfm_pkg::NUM_W-1:0]     quo_reg, quo_next;
    logic [pfm_pkg::MAG_W-1:0]     rem_reg, rem_next;
    logic [pfm_pkg::MAG_W-1:0]     den_reg, den_next;
    logic [pfm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    // Radix steps for one cycle
    logic [pfm_pkg::NUM_W-1:0] q_step;
    logic [pfm_pkg::MAG_W-1:0] r_step;
    logic [pfm_pkg::MAG_W:0]   trial;

    always_comb
    begin
        q_step = quo_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int i = 0; i < pfm_pkg::DIV_RADIX; i++)
        begin
            trial  = {r_step, q_step[pfm_pkg::NUM_W-1]};
            q_step = {q_step[pfm_pkg::NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                r_step    = pfm_pkg::MAG_W'(trial - {1'b0, den_reg});
                q_step[0] = 1'b1;
            end
            else
            begin
                r_step = trial[pfm_pkg::MAG_W-1:0];
            end
        end
    end

    // Sequencing
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = pfm_pkg::DIV_CNT_W'(pfm_pkg::DIV_CYCLES - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - pfm_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/pfm_dp.sv
// ----------------------------------------------------------------------------
// pfm_dp
// Datapath: config registers, bridge state, off-gap arithmetic, output beat.
// ----------------------------------------------------------------------------
module pfm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pfm_pkg::CFG_W-1:0]     cfg_data,
    // input item
    input  logic [pfm_pkg::KIND_W-1:0]    in_kind,
    input  logic [pfm_pkg::DUTY_W-1:0]    in_duty,
    // output beat
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfm_pkg::OUT_W-1:0]     out_data,
    // control
    input  pfm_pkg::cmd_t                 cmd,
    output pfm_pkg::status_t              status
);

    // Configuration
    logic [pfm_pkg::CFG_W-1:0] on_time_reg, dead_time_reg;

    // Captured item
    logic [pfm_pkg::KIND_W-1:0]        kind_reg;
    logic signed [pfm_pkg::DUTY_W-1:0] duty_in_reg;

    // Bridge state
    logic [pfm_pkg::COUNT_WIDTH-1:0]   wait_reg, wait_next;
    logic                              braking_reg, braking_next;
    logic signed [pfm_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic                              level_a_reg, level_a_next;
    logic                              level_b_reg, level_b_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [pfm_pkg::OUT_W-1:0]    out_data_reg;

    // Arithmetic
    logic [pfm_pkg::NUM_W-1:0]       full_reg;
    logic [pfm_pkg::NUM_W-1:0]       quo;
    logic                            div_done;
    logic [pfm_pkg::WIDE_W-1:0]      gap_wide;
    logic [pfm_pkg::COUNT_WIDTH-1:0] gap_count;
    logic [pfm_pkg::COUNT_WIDTH-1:0] on_count, dead_count;

    // Decode of the stored duty
    logic                     duty_nz, fwd, act_level, opp_level;
    logic [pfm_pkg::MAG_W-1:0] mag;
    logic signed [pfm_pkg::DUTY_W-1:0] duty_sat;

    always_comb
    begin
        duty_nz   = (duty_reg != '0);
        fwd       = duty_nz && !duty_reg[pfm_pkg::DUTY_W-1];
        mag       = duty_reg[pfm_pkg::DUTY_W-1] ? pfm_pkg::MAG_W'(-duty_reg)
                                                : pfm_pkg::MAG_W'(duty_reg);
        act_level = fwd ? level_a_reg : level_b_reg;
        opp_level = fwd ? level_b_reg : level_a_reg;
    end

    // Saturate the commanded duty
    always_comb
    begin
        if (duty_in_reg > pfm_pkg::DUTY_POS)
        begin
            duty_sat = pfm_pkg::DUTY_POS;
        end
        else if (duty_in_reg < pfm_pkg::DUTY_NEG)
        begin
            duty_sat = pfm_pkg::DUTY_NEG;
        end
        else
        begin
            duty_sat = duty_in_reg;
        end
    end

    // Off gap = on_time*100/|duty| - on_time, floored at zero
    pfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (full_reg),
        .den   (mag),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        if (quo >= pfm_pkg::NUM_W'(on_time_reg))
        begin
            gap_wide = pfm_pkg::WIDE_W'(quo - pfm_pkg::NUM_W'(on_time_reg));
        end
        else
        begin
            gap_wide = '0;
        end
        gap_count  = pfm_pkg::clamp_count(gap_wide);
        on_count   = pfm_pkg::clamp_count(pfm_pkg::WIDE_W'(on_time_reg));
        dead_count = pfm_pkg::clamp_count(pfm_pkg::WIDE_W'(dead_time_reg));
    end

    // Status to controller
    always_comb
    begin
        status.need_div = (kind_reg == pfm_pkg::KIND_TICK) && (wait_reg == '0) &&
                          !braking_reg && duty_nz && !opp_level && act_level;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    // Next bridge state for the captured item
    always_comb
    begin
        wait_next    = wait_reg;
        braking_next = braking_reg;
        duty_next    = duty_reg;
        level_a_next = level_a_reg;
        level_b_next = level_b_reg;
        case (kind_reg)
            pfm_pkg::KIND_TICK:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - pfm_pkg::COUNT_WIDTH'(1);
                end
                else if (braking_reg)
                begin
                    if (level_a_reg || level_b_reg)
                    begin
                        level_a_next = 1'b0;
                        level_b_next = 1'b0;
                        wait_next    = dead_count;
                    end
                    else
                    begin
                        level_a_next = 1'b1;
                        level_b_next = 1'b1;
                    end
                end
                else if (duty_nz)
                begin
                    if (opp_level)
                    begin
                        level_a_next = 1'b0;
                        level_b_next = 1'b0;
                        wait_next    = dead_count;
                    end
                    else if (act_level)
                    begin
                        if (fwd)
                        begin
                            level_a_next = 1'b0;
                        end
                        else
                        begin
                            level_b_next = 1'b0;
                        end
                        wait_next = gap_count;
                    end
                    else
                    begin
                        if (fwd)
                        begin
                            level_a_next = 1'b1;
                        end
                        else
                        begin
                            level_b_next = 1'b1;
                        end
                        wait_next = on_count;
                    end
                end
                else
                begin
                    level_a_next = 1'b0;
                    level_b_next = 1'b0;
                end
            end
            pfm_pkg::KIND_DRIVE:
            begin
                braking_next = 1'b0;
                duty_next    = duty_sat;
            end
            pfm_pkg::KIND_BRAKE:
            begin
                braking_next = 1'b1;
            end
            default:
            begin
                // unused kind leaves the state alone
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg   <= pfm_pkg::CFG_W'(10);
            dead_time_reg <= pfm_pkg::CFG_W'(10);
            wait_reg      <= '0;
            braking_reg   <= 1'b0;
            duty_reg      <= '0;
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == pfm_pkg::CFG_ON_TIME)
            begin
                on_time_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == pfm_pkg::CFG_DEAD_TIME)
            begin
                dead_time_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                wait_reg    <= wait_next;
                braking_reg <= braking_next;
                duty_reg    <= duty_next;
                level_a_reg <= level_a_next;
                level_b_reg <= level_b_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg    <= in_kind;
            duty_in_reg <= in_duty;
        end
        if (cmd.mul)
        begin
            full_reg <= pfm_pkg::NUM_W'(on_time_reg) * pfm_pkg::NUM_W'(pfm_pkg::DUTY_FULL);
        end
        if (cmd.commit)
        begin
            out_data_reg <= pfm_pkg::OUT_W'({duty_next, level_b_next, level_a_next});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/pfm_ctrl.sv
// ----------------------------------------------------------------------------
// pfm_ctrl
// Controller: sequences capture, off-gap division and state commit.
// ----------------------------------------------------------------------------
module pfm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfm_pkg::status_t  status,
    output pfm_pkg::cmd_t     cmd
);

    pfm_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            pfm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = pfm_pkg::ST_DECIDE;
                end
            end
            pfm_pkg::ST_DECIDE:
            begin
                if (status.need_div)
                begin
                    cmd.mul    = 1'b1;
                    state_next = pfm_pkg::ST_MUL;
                end
                else
                begin
                    state_next = pfm_pkg::ST_COMMIT;
                end
            end
            pfm_pkg::ST_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = pfm_pkg::ST_DIV;
            end
            pfm_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = pfm_pkg::ST_COMMIT;
                end
            end
            pfm_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = pfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pfm_h_bridge_motor_driver.sv
// ----------------------------------------------------------------------------
// Flow: an accepted beat passes decide, then commit; a tick that starts an off
//   gap first does the multiply, then the iterative radix-8 divide.
// The controller handles one beat at a time: no new beat is taken until the
//   result is committed, and commit waits for a free output slot.
// Reset: async active low; pins low, duty 0, counter 0, on/dead time 10.
// ----------------------------------------------------------------------------
// pfm_h_bridge_motor_driver
// Pulse frequency modulated H-bridge driver with brake and dead time.
// ----------------------------------------------------------------------------
module pfm_h_bridge_motor_driver (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pfm_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pfm_pkg::DUTY_W-1:0]    s_axis_tdata,   // [7:0] duty
    input  logic [pfm_pkg::KIND_W-1:0]    s_axis_tuser,   // [1:0] kind
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pfm_pkg::OUT_W-1:0]     m_axis_tdata    // [0] pin_a, [1] pin_b,
                                                          // [9:2] duty_now, rest 0
);

    pfm_pkg::cmd_t    cmd;
    pfm_pkg::status_t status;

    pfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_axis_tuser),
        .in_duty   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // Commit only into a free output slot
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output beat still pending");

    // Division only started for an off-gap tick
    a_div_needed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.need_div)
        else $error("divider started without an off gap to compute");

    // One beat in flight: ready drops after acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat accepted while first still in work");

endmodule

FILE: tb/pfm_h_bridge_motor_driver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfm_h_bridge_motor_driver_test
// Self-checking bench for the PFM H-bridge driver. A queue-fed stream driver
// sends tick, drive and brake beats in random bursts. A result sink stalls on
// a shifting pattern, with one long hold-off. A beat-level software copy of
// the pin pattern predicts every result beat, which is then checked field by
// field. On and dead time are swept through several settings, extremes included.
// ----------------------------------------------------------------------------
module pfm_h_bridge_motor_driver_test;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 3000;   // cycles with no beat moving on either side
    localparam int SETTLE        = 30;     // margin after the queues drain
    localparam int HOLD_OFF      = 300;
    localparam int MAX_ERR_LINES = 40;
    localparam int PHASE_BEATS   = 120;

    localparam logic [pfm_pkg::KIND_W-1:0]      KIND_SPARE = 2'd3;
    localparam logic [pfm_pkg::COUNT_WIDTH-1:0] COUNT_TOP  = '1;

    typedef struct packed {
        logic [pfm_pkg::KIND_W-1:0] kind;
        logic [pfm_pkg::DUTY_W-1:0] duty;
    } motor_cmd_t;

    typedef struct packed {
        logic                              pin_a;
        logic                              pin_b;
        logic signed [pfm_pkg::DUTY_W-1:0] duty_now;
    } bridge_pins_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    // DUT ports
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       cfg_we        = 1'b0;
    logic                       cfg_index     = 1'b0;
    logic [pfm_pkg::CFG_W-1:0]  cfg_data      = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [pfm_pkg::DUTY_W-1:0] s_axis_tdata  = '0;    // [7:0] duty
    logic [pfm_pkg::KIND_W-1:0] s_axis_tuser  = '0;    // [1:0] kind
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [pfm_pkg::OUT_W-1:0]  m_axis_tdata;  // [0] pin_a, [1] pin_b, [9:2] duty_now

    // Pin pattern copy, at reset values
    logic [pfm_pkg::CFG_W-1:0]         on_len     = 16'd10;
    logic [pfm_pkg::CFG_W-1:0]         dead_len   = 16'd10;
    logic [pfm_pkg::COUNT_WIDTH-1:0]   pulse_wait = '0;
    logic                              brake_on   = 1'b0;
    logic                              fwd_pin    = 1'b0;
    logic                              rev_pin    = 1'b0;
    logic signed [pfm_pkg::DUTY_W-1:0] duty_held  = '0;

    motor_cmd_t   cmd_backlog[$];
    bridge_pins_t pin_forecast_q[$];

    // Bookkeeping
    int n_ticks, n_drives, n_brakes, n_spare;
    int cfg_writes, err_count, in_count, out_count, queued_count;
    int in_stall_cycles, idle_cycles;

    // Driver and sink state
    motor_cmd_t   next_cmd;
    motor_cmd_t   seen_cmd;
    bridge_pins_t want;
    logic         in_taken = 1'b0;
    logic         offering;
    int           burst_left, idle_left;
    sink_mode_t   sink_mode = SINK_OPEN;
    int           sink_cycle, hold_left;
    logic         hold_done = 1'b0;
    logic         take;

    pfm_h_bridge_motor_driver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Off gap after an on pulse: on_len*100/|duty| - on_len, floored at zero
    function automatic logic [pfm_pkg::COUNT_WIDTH-1:0] gap_after_pulse(input int mag);
        longint whole;
        longint gap;
        whole = (longint'(on_len) * pfm_pkg::DUTY_FULL) / mag;
        gap   = (whole >= longint'(on_len)) ? whole - longint'(on_len) : 0;
        return (gap > longint'(COUNT_TOP)) ? COUNT_TOP : pfm_pkg::COUNT_WIDTH'(gap);
    endfunction

    // One timer tick: count down, or move the pin pattern one step
    function automatic void tick_pattern();
        logic ahead;
        logic lead;
        logic trail;
        int   mag;
        if (pulse_wait != 0)
        begin
            pulse_wait = pulse_wait - pfm_pkg::COUNT_WIDTH'(1);
            return;
        end
        if (brake_on)
        begin
            if (fwd_pin || rev_pin)
            begin
                fwd_pin    = 1'b0;
                rev_pin    = 1'b0;
                pulse_wait = pfm_pkg::COUNT_WIDTH'(dead_len);
            end
            else
            begin
                // high phase leaves the counter at zero
                fwd_pin = 1'b1;
                rev_pin = 1'b1;
            end
        end
        else if (duty_held != 0)
        begin
            ahead = (duty_held > 0);
            mag   = ahead ? int'(duty_held) : -int'(duty_held);
            lead  = ahead ? fwd_pin : rev_pin;
            trail = ahead ? rev_pin : fwd_pin;
            if (trail)
            begin
                // reversing: both low for the dead time first
                fwd_pin    = 1'b0;
                rev_pin    = 1'b0;
                pulse_wait = pfm_pkg::COUNT_WIDTH'(dead_len);
            end
            else
            begin
                if (lead)
                    pulse_wait = gap_after_pulse(mag);
                else
                    pulse_wait = pfm_pkg::COUNT_WIDTH'(on_len);
                if (ahead)
                    fwd_pin = !lead;
                else
                    rev_pin = !lead;
            end
        end
        else
        begin
            fwd_pin = 1'b0;
            rev_pin = 1'b0;
        end
    endfunction

    // Apply one accepted beat and return the pins it should leave behind
    function automatic bridge_pins_t bridge_step(input motor_cmd_t cmd);
        logic signed [pfm_pkg::DUTY_W-1:0] req;
        bridge_pins_t                      res;
        req = cmd.duty;
        case (cmd.kind)
            pfm_pkg::KIND_TICK:
            begin
                n_ticks++;
                tick_pattern();
            end
            pfm_pkg::KIND_DRIVE:
            begin
                n_drives++;
                if (req > pfm_pkg::DUTY_POS)
                    req = pfm_pkg::DUTY_POS;
                else if (req < pfm_pkg::DUTY_NEG)
                    req = pfm_pkg::DUTY_NEG;
                brake_on  = 1'b0;
                duty_held = req;
            end
            pfm_pkg::KIND_BRAKE:
            begin
                n_brakes++;
                brake_on = 1'b1;
            end
            default:
                n_spare++;
        endcase
        res.pin_a    = fwd_pin;
        res.pin_b    = rev_pin;
        res.duty_now = duty_held;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        if (err_count < MAX_ERR_LINES)
            $display("%0t: result %0d, %s: expected %0h, got %0h",
                     $time, out_count, what, want_v, got_v);
        err_count++;
    endtask

    // Result check and input capture, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_count++;
                if (pin_forecast_q.size() == 0)
                    report_mismatch("beat with nothing expected", '0, 32'(m_axis_tdata));
                else
                begin
                    want = pin_forecast_q.pop_front();
                    if (m_axis_tdata[0] !== want.pin_a)
                        report_mismatch("pin_a", 32'(want.pin_a), 32'(m_axis_tdata[0]));
                    if (m_axis_tdata[1] !== want.pin_b)
                        report_mismatch("pin_b", 32'(want.pin_b), 32'(m_axis_tdata[1]));
                    if (m_axis_tdata[9:2] !== want.duty_now)
                        report_mismatch("duty_now", 32'(unsigned'(want.duty_now)),
                                        32'(m_axis_tdata[9:2]));
                    if (m_axis_tdata[pfm_pkg::OUT_W-1:10] !== '0)
                        report_mismatch("padding", '0,
                                        32'(m_axis_tdata[pfm_pkg::OUT_W-1:10]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_count++;
                seen_cmd.kind = s_axis_tuser;
                seen_cmd.duty = s_axis_tdata;
                pin_forecast_q.push_back(bridge_step(seen_cmd));
            end
            if (s_axis_tvalid && !s_axis_tready)
                in_stall_cycles++;
            in_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Watchdog on beats moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("pfm_h_bridge_motor_driver test failed");
                $finish;
            end
        end
    end

    function automatic void pick_burst();
        if ($urandom_range(0, 4) == 0)
        begin
            // a stretch with no idling
            burst_left = $urandom_range(30, 60);
            idle_left  = 0;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            idle_left  = $urandom_range(1, 10);
        end
    endfunction

    // Stream driver: bursts of beats from the backlog, gaps in between
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            offering = s_axis_tvalid && !in_taken;
            if (!offering)
            begin
                if (idle_left != 0)
                    idle_left--;
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    offering = 1'b1;
                    if (burst_left != 0)
                        burst_left--;
                    else
                        pick_burst();
                end
            end
            s_axis_tvalid <= offering;
            s_axis_tuser  <= next_cmd.kind;
            s_axis_tdata  <= next_cmd.duty;
        end
    end

    // Result sink: stall mode redrawn at random on a sink cycle counter, one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            sink_cycle++;
            if (sink_cycle % 64 == 0)
                sink_mode = sink_mode_t'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (!hold_done && in_count >= 200)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF - 1;
                take      = 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:   take = 1'b1;
                    SINK_COIN:   take = 1'($urandom_range(0, 1));
                    SINK_SPARSE: take = ($urandom_range(0, 3) == 0);
                    default:     take = (sink_cycle % 8) < 5;
                endcase
            end
            m_axis_tready <= take;
        end
    end

    function automatic void queue_cmd(input logic [pfm_pkg::KIND_W-1:0] kind,
                                      input logic [pfm_pkg::DUTY_W-1:0] duty);
        motor_cmd_t c;
        c.kind = kind;
        c.duty = duty;
        cmd_backlog.push_back(c);
        queued_count++;
    endfunction

    // Register write; only called with the block idle
    task automatic write_reg(input logic idx, input logic [pfm_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pfm_pkg::CFG_ON_TIME)
            on_len = value;
        else
            dead_len = value;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (in_count != queued_count || pin_forecast_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Mostly ticks so the pattern keeps moving; commands mixed in
    function automatic motor_cmd_t random_cmd();
        int         pick;
        int         mag;
        motor_cmd_t c;
        pick   = $urandom_range(0, 99);
        c.duty = pfm_pkg::DUTY_W'($urandom);
        if (pick < 74)
            c.kind = pfm_pkg::KIND_TICK;
        else if (pick < 88)
        begin
            c.kind = pfm_pkg::KIND_DRIVE;
            pick   = $urandom_range(0, 19);
            if (pick < 13)
                mag = $urandom_range(20, 100);
            else if (pick < 16)
                // low duty means a long gap; keep it short unless pulses are tiny
                mag = (on_len <= 2) ? $urandom_range(1, 19) : $urandom_range(10, 19);
            else if (pick < 19)
                mag = $urandom_range(101, 128);
            else
                mag = 0;
            c.duty = $urandom_range(0, 1) ? pfm_pkg::DUTY_W'(-mag) : pfm_pkg::DUTY_W'(mag);
        end
        else if (pick < 95)
            c.kind = pfm_pkg::KIND_BRAKE;
        else
            c.kind = KIND_SPARE;
        return c;
    endfunction

    task automatic run_random_phase(input logic [pfm_pkg::CFG_W-1:0] on_v,
                                    input logic [pfm_pkg::CFG_W-1:0] dead_v,
                                    input int count);
        motor_cmd_t c;
        write_reg(pfm_pkg::CFG_ON_TIME, on_v);
        write_reg(pfm_pkg::CFG_DEAD_TIME, dead_v);
        repeat (count)
        begin
            c = random_cmd();
            queue_cmd(c.kind, c.duty);
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        int guard;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: saturation, pulse/gap, reversal, brake, zero duty, unused kind
        write_reg(pfm_pkg::CFG_ON_TIME, 16'd2);
        write_reg(pfm_pkg::CFG_DEAD_TIME, 16'd1);
        queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
        queue_cmd(KIND_SPARE, 8'h5A);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'h7F);
        repeat (5) queue_cmd(pfm_pkg::KIND_TICK, 8'hA5);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'h80);
        repeat (5) queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
        queue_cmd(pfm_pkg::KIND_BRAKE, 8'hFF);
        repeat (6) queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'h00);
        queue_cmd(pfm_pkg::KIND_TICK, 8'h3C);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'h9C);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'h64);
        wait_drained();

        // Step to the end of a forward pulse with the counter at zero
        write_reg(pfm_pkg::CFG_ON_TIME, 16'd3);
        write_reg(pfm_pkg::CFG_DEAD_TIME, 16'd2);
        queue_cmd(pfm_pkg::KIND_DRIVE, pfm_pkg::DUTY_POS);
        wait_drained();
        for (guard = 0; guard < 200 && !(fwd_pin && !rev_pin && pulse_wait == 0); guard++)
        begin
            queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
            wait_drained();
        end
        if (fwd_pin && !rev_pin && pulse_wait == 0)
        begin
            // widest divide: full on time at full duty gives no off gap
            write_reg(pfm_pkg::CFG_ON_TIME, '1);
            write_reg(pfm_pkg::CFG_DEAD_TIME, '1);
            queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
            queue_cmd(KIND_SPARE, 8'hFF);
            wait_drained();
        end

        // Zero on pulse and zero dead time, with a reversal
        write_reg(pfm_pkg::CFG_ON_TIME, '0);
        write_reg(pfm_pkg::CFG_DEAD_TIME, '0);
        repeat (4) queue_cmd(pfm_pkg::KIND_TICK, 8'h00);
        queue_cmd(pfm_pkg::KIND_DRIVE, 8'hDB);
        repeat (4) queue_cmd(pfm_pkg::KIND_TICK, 8'hFF);
        wait_drained();

        // Random phases across on/dead time settings
        run_random_phase(16'd10, 16'd10, PHASE_BEATS);
        run_random_phase(16'd0, 16'd0, PHASE_BEATS);
        run_random_phase(16'd1, 16'd3, PHASE_BEATS);
        run_random_phase(16'd4, 16'd0, PHASE_BEATS);
        run_random_phase(16'd0, 16'd2, PHASE_BEATS);
        run_random_phase(16'd6, 16'd5, PHASE_BEATS);
        run_random_phase(pfm_pkg::CFG_W'($urandom_range(0, 7)),
                         pfm_pkg::CFG_W'($urandom_range(0, 7)),
                         PHASE_BEATS);
        run_random_phase(16'd2, 16'd1, PHASE_BEATS + 10);

        $display("Covered %0d beats in, %0d out: %0d ticks, %0d drives, %0d brakes, %0d unused",
                 in_count, out_count, n_ticks, n_drives, n_brakes, n_spare);
        $display("%0d register writes, input held off by the block for %0d cycles",
                 cfg_writes, in_stall_cycles);
        if (err_count == 0)
            $display("pfm_h_bridge_motor_driver test passed");
        else
            $display("pfm_h_bridge_motor_driver test failed");
        $finish;
    end

endmodule
